/* rtl/core/cbor_pkg.sv */
// Package: shared types and constants of the CBOR item delimiter.
`timescale 1ns / 1ps
`default_nettype none
package cbor_pkg;
    localparam int MaxDepth  = 8;
    localparam int DepthW    = 4;
    localparam int IdxW      = 3;
    localparam logic [4:0] InfoArg = 5'h18;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MAJOR7   = 3'd1,
        ST_INFO     = 3'd2,
        ST_DEEP     = 3'd3,
        ST_MAPCOUNT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CMD_CLOSE = 3'd0,
        CMD_OPEN  = 3'd1,
        CMD_FAIL  = 3'd2,
        CMD_NONE  = 3'd3
    } cmd_t;

    // one classified word from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] count;
        status_t     code;
        logic [31:0] bytes;
    } job_t;
endpackage
`default_nettype wire

/* rtl/core/cbor_item_delimiter_top.sv */
// Top level of the CBOR top-level item delimiter.
`timescale 1ns / 1ps
`default_nettype none
// Takes a CBOR stream one byte word per handshake and emits one word per
// completed top-level item (byte length, saturating at 32 bits) or per error
// (length 0, status 1..4), after which parsing restarts at a head byte.
// The front holds one job at a time and takes no new byte until the back has
// finished it. A byte that only advances the parse (argument byte, string
// payload byte, tag head, string head) raises no job; a byte that opens a
// container or raises an error is finished once the back takes it; a byte that
// closes an element waits while the back walks the stack, one entry being read
// and decremented per cycle for each enclosing container that it closes. A job
// also waits while a result word is held by m_tready low. No clearing pass
// after reset: stack entries are only read after they have been pushed.
module cbor_item_delimiter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic [39:0]      m_tdata,   // item_length[31:0], status[34:32]
    output logic             m_tvalid,
    input  wire logic        m_tready
);
    import cbor_pkg::*;

    job_t job;
    logic job_valid, job_ready, flush;

    // front's job handshake: back signals job_ready once the job is finished
    cbor_front u_front (
        .clk(clk), .rst_n(rst_n), .data_byte(s_tdata), .in_valid(s_tvalid),
        .in_ready(s_tready), .job(job), .job_valid(job_valid),
        .job_ready(job_ready), .flush(flush)
    );

    cbor_back u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_ready(job_ready), .flush(flush), .m_tdata(m_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready)
    );
endmodule
`default_nettype wire

/* rtl/core/cbor_front.sv */
// Front: decodes heads, arguments and string payloads into jobs.
`timescale 1ns / 1ps
`default_nettype none
module cbor_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [7:0]   data_byte,
    input  wire logic         in_valid,
    output logic              in_ready,
    output cbor_pkg::job_t    job,
    output logic              job_valid,
    input  wire logic         job_ready,
    input  wire logic         flush
);
    import cbor_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_ARG  = 3'b010,
        PH_PAY  = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  major_reg, major_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] pay_reg, pay_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] cnt_inc;
    job_t        job_reg;
    job_t        j;
    logic        emit;
    logic [63:0] arg;
    logic [2:0]  maj;
    logic [4:0]  info;
    logic        fire;

    // one job in flight: wait for the back to finish before next word
    logic busy_reg;
    assign in_ready = !busy_reg;
    assign fire     = in_valid && in_ready;
    assign job_valid = busy_reg;
    assign job      = job_reg;

    always_comb
    begin
        phase_next = phase_reg;
        major_next = major_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        pay_next   = pay_reg;
        cnt_inc    = (cnt_reg == 32'hFFFF_FFFF) ? cnt_reg : cnt_reg + 32'd1;
        cnt_next   = cnt_inc;
        emit       = 1'b0;
        j.cmd      = CMD_NONE;
        j.count    = 64'd0;
        j.code     = ST_OK;
        j.bytes    = cnt_inc;
        arg        = 64'd0;
        maj        = major_reg;
        info       = data_byte[4:0];
        case (phase_reg)
            PH_ARG:
            begin
                acc_next  = {acc_reg[55:0], data_byte};
                left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    emit = 1'b1;
                    arg  = acc_next;
                end
            end
            PH_PAY:
            begin
                pay_next = pay_reg - 64'd1;
                if (pay_next == 64'd0)
                begin
                    emit  = 1'b1;
                    j.cmd = CMD_CLOSE;
                    phase_next = PH_HEAD;
                end
            end
            default:
            begin
                maj        = data_byte[7:5];
                major_next = maj;
                if (maj == 3'd7)
                begin
                    j.cmd = CMD_FAIL; j.code = ST_MAJOR7; emit = 1'b1;
                end
                else if (info >= 5'd28)
                begin
                    j.cmd = CMD_FAIL; j.code = ST_INFO; emit = 1'b1;
                end
                else if (info < InfoArg)
                begin
                    emit = 1'b1;
                    arg  = {59'd0, info};
                end
                else
                begin
                    acc_next   = 64'd0;
                    left_next  = 4'd1 << info[1:0];
                    phase_next = PH_ARG;
                end
            end
        endcase
        // head complete: dispatch by major type
        if (emit && j.cmd == CMD_NONE && !(phase_reg == PH_PAY))
        begin
            phase_next = PH_HEAD;
            case (maj)
                3'd0, 3'd1: j.cmd = CMD_CLOSE;
                3'd2, 3'd3:
                    if (arg == 64'd0) j.cmd = CMD_CLOSE;
                    else
                    begin
                        pay_next = arg; phase_next = PH_PAY; emit = 1'b0;
                    end
                3'd4:
                    if (arg == 64'd0) j.cmd = CMD_CLOSE;
                    else
                    begin
                        j.cmd = CMD_OPEN; j.count = arg;
                    end
                3'd5:
                    if (arg == 64'd0) j.cmd = CMD_CLOSE;
                    else if (arg[63])
                    begin
                        j.cmd = CMD_FAIL; j.code = ST_MAPCOUNT;
                    end
                    else
                    begin
                        j.cmd = CMD_OPEN; j.count = {arg[62:0], 1'b0};
                    end
                3'd6: emit = 1'b0;
                default:
                begin
                    j.cmd = CMD_FAIL; j.code = ST_MAJOR7;
                end
            endcase
        end
        if (j.cmd == CMD_FAIL)
        begin
            phase_next = PH_HEAD;
            major_next = 3'd0;
            left_next  = 4'd0;
            acc_next   = 64'd0;
            pay_next   = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            major_reg <= 3'd0;
            left_reg  <= 4'd0;
            acc_reg   <= 64'd0;
            pay_reg   <= 64'd0;
            cnt_reg   <= 32'd0;
            busy_reg  <= 1'b0;
            job_reg   <= '0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                major_reg <= major_next;
                left_reg  <= left_next;
                acc_reg   <= acc_next;
                pay_reg   <= pay_next;
                if (emit)
                begin
                    busy_reg <= 1'b1;
                    job_reg  <= j;
                end
            end
            else if (busy_reg && job_ready)
                busy_reg <= 1'b0;
            // back reports item end or error: count restarts
            if (flush)
                cnt_reg <= 32'd0;
            else if (fire)
                cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/cbor_back.sv */
// Back: nesting stack, cascading closes and result register.
`timescale 1ns / 1ps
`default_nettype none
module cbor_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cbor_pkg::job_t job,
    input  wire logic           job_valid,
    output logic                job_ready,
    output logic                flush,
    output logic [39:0]         m_tdata,
    output logic                m_tvalid,
    input  wire logic           m_tready
);
    import cbor_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_POP  = 2'b10
    } bk_t;

    bk_t               st_reg, st_next;
    logic [DepthW-1:0] lvl_reg, lvl_next;
    logic [63:0]       stack [MaxDepth];
    logic [63:0]       top_reg;
    logic [31:0]       bytes_reg, bytes_next;
    logic [39:0]       tdata_reg, tdata_next;
    logic              full_reg, full_next;
    logic              out_free;
    logic              take;
    logic              is_last;
    logic              push;
    logic              dec;
    logic [IdxW-1:0]   ti;
    logic [IdxW-1:0]   rd_idx;

    assign m_tvalid = full_reg;
    assign m_tdata  = tdata_reg;
    assign out_free = !full_reg || m_tready;
    assign take     = st_reg == BK_IDLE && job_valid && out_free;
    assign is_last  = top_reg == 64'd1;
    assign ti       = IdxW'(lvl_reg - DepthW'(1));
    assign push     = take && job.cmd == CMD_OPEN && lvl_reg < DepthW'(MaxDepth);
    assign dec      = st_reg == BK_POP && lvl_reg != '0;
    // popping a level: fetch the entry beneath it for the next cycle
    assign rd_idx   = (dec && is_last) ? IdxW'(lvl_reg - DepthW'(2)) : ti;

    always_ff @(posedge clk)
    begin
        top_reg <= stack[rd_idx];
        if (push)
            stack[lvl_reg[IdxW-1:0]] <= job.count;
        else if (dec)
            stack[ti] <= top_reg - 64'd1;
    end

    always_comb
    begin
        st_next    = st_reg;
        lvl_next   = lvl_reg;
        bytes_next = bytes_reg;
        tdata_next = tdata_reg;
        full_next  = full_reg && !m_tready;
        job_ready  = 1'b0;
        flush      = 1'b0;
        case (st_reg)
            BK_POP:
            begin
                // top_reg holds entry at lvl-1
                if (lvl_reg == '0)
                begin
                    tdata_next = {5'd0, ST_OK, bytes_reg};
                    full_next  = 1'b1;
                    flush      = 1'b1;
                    job_ready  = 1'b1;
                    st_next    = BK_IDLE;
                end
                else if (!is_last)
                begin
                    job_ready = 1'b1;
                    st_next   = BK_IDLE;
                end
                else
                    lvl_next = lvl_reg - DepthW'(1);
            end
            default:
                if (take)
                begin
                    bytes_next = job.bytes;
                    job_ready  = 1'b1;
                    case (job.cmd)
                        CMD_OPEN:
                            if (lvl_reg >= DepthW'(MaxDepth))
                            begin
                                tdata_next = {5'd0, ST_DEEP, 32'd0};
                                full_next  = 1'b1;
                                flush      = 1'b1;
                                lvl_next   = '0;
                            end
                            else
                                lvl_next = lvl_reg + DepthW'(1);
                        CMD_FAIL:
                        begin
                            tdata_next = {5'd0, job.code, 32'd0};
                            full_next  = 1'b1;
                            flush      = 1'b1;
                            lvl_next   = '0;
                        end
                        CMD_CLOSE:
                        begin
                            job_ready = 1'b0;
                            st_next   = BK_POP;
                        end
                        default: ;
                    endcase
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= BK_IDLE;
            lvl_reg   <= '0;
            bytes_reg <= 32'd0;
            tdata_reg <= 40'd0;
            full_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            lvl_reg   <= lvl_next;
            bytes_reg <= bytes_next;
            tdata_reg <= tdata_next;
            full_reg  <= full_next;
        end
    end
endmodule
`default_nettype wire

/* tb/tb_cbor_item_delimiter_top.sv */
// Testbench for the CBOR top-level item delimiter: self-checking stream test.
`timescale 1ns / 1ps
module tb_cbor_item_delimiter_top;
    import cbor_pkg::*;

    typedef struct packed {
        logic [31:0] length;
        status_t     status;
    } item_end_t;

    logic        clk;
    logic        rst_n;
    logic [7:0]  s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;

    cbor_item_delimiter_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),    // data_byte
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),    // item_length[31:0], status[34:32]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Parser state mirrored from the block's specification
    logic [1:0]  p_phase;
    logic [2:0]  p_major;
    logic [3:0]  p_arg_left;
    logic [63:0] p_arg;
    logic [63:0] p_payload_left;
    logic [3:0]  p_level;
    logic [63:0] p_owed [MaxDepth];
    logic [31:0] p_count;

    logic [7:0]  byte_queue [$];
    item_end_t   item_ends [$];
    int          errors;
    int          words_sent;
    int          words_seen;
    int          error_words;
    longint      cycles;
    bit          stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void parser_clear();
        p_phase        = 2'd0;
        p_major        = 3'd0;
        p_arg_left     = 4'd0;
        p_arg          = 64'd0;
        p_payload_left = 64'd0;
        p_level        = 4'd0;
        p_count        = 32'd0;
    endfunction

    function automatic void parser_fail(status_t code);
        item_end_t r;
        parser_clear();
        r.length = 32'd0;
        r.status = code;
        item_ends.push_back(r);
    endfunction

    // An element has closed; cascade through enclosing containers.
    function automatic void element_closed();
        item_end_t r;
        p_phase = 2'd0;
        while (p_level > 0)
        begin
            p_owed[p_level - 1] = p_owed[p_level - 1] - 64'd1;
            if (p_owed[p_level - 1] != 64'd0)
                return;
            p_level = p_level - 4'd1;
        end
        r.length = p_count;
        r.status = ST_OK;
        item_ends.push_back(r);
        p_count = 32'd0;
    endfunction

    function automatic void container_open(logic [63:0] n);
        if (p_level >= MaxDepth)
        begin
            parser_fail(ST_DEEP);
            return;
        end
        p_owed[p_level] = n;
        p_level = p_level + 4'd1;
        p_phase = 2'd0;
    endfunction

    function automatic void head_complete(logic [63:0] a);
        case (p_major)
            3'd0, 3'd1: element_closed();
            3'd2, 3'd3:
                if (a == 0)
                    element_closed();
                else
                begin
                    p_payload_left = a;
                    p_phase = 2'd2;
                end
            3'd4:
                if (a == 0)
                    element_closed();
                else
                    container_open(a);
            3'd5:
                if (a == 0)
                    element_closed();
                else if (a[63])
                    parser_fail(ST_MAPCOUNT);
                else
                    container_open(a << 1);
            3'd6: p_phase = 2'd0;
            default: parser_fail(ST_MAJOR7);
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        if (p_count != 32'hFFFF_FFFF)
            p_count = p_count + 32'd1;
        if (p_phase == 2'd1)
        begin
            p_arg = {p_arg[55:0], b};
            if (p_arg_left > 0)
                p_arg_left = p_arg_left - 4'd1;
            if (p_arg_left == 0)
                head_complete(p_arg);
        end
        else if (p_phase == 2'd2)
        begin
            if (p_payload_left > 0)
                p_payload_left = p_payload_left - 64'd1;
            if (p_payload_left == 0)
                element_closed();
        end
        else
        begin
            p_major = b[7:5];
            if (p_major == 3'd7)
                parser_fail(ST_MAJOR7);
            else if (b[4:0] >= 5'd28)
                parser_fail(ST_INFO);
            else if (b[4:0] < InfoArg)
                head_complete({59'd0, b[4:0]});
            else
            begin
                p_arg = 64'd0;
                p_arg_left = 4'd1 << b[1:0];
                p_phase = 2'd1;
            end
        end
    endfunction

    // ---- stimulus builders ----
    function automatic void put_head(int major, logic [63:0] a);
        int nb;
        if (a < 24)
        begin
            byte_queue.push_back({major[2:0], a[4:0]});
            return;
        end
        nb = (a < 256) ? 1 : (a < 65536) ? 2 : (a < 64'h1_0000_0000) ? 4 : 8;
        byte_queue.push_back({major[2:0], 5'd24 + ((nb == 1) ? 5'd0 : (nb == 2) ? 5'd1
                              : (nb == 4) ? 5'd2 : 5'd3)});
        for (int i = nb - 1; i >= 0; i--)
            byte_queue.push_back(a[i*8 +: 8]);
    endfunction

    // A random item, well-formed unless a nesting chain overflows; depth keeps nesting bounded
    function automatic void put_item(int depth);
        int kind;
        int n;
        logic [63:0] a;
        kind = $urandom_range(0, 9);
        if (depth >= 5 && kind >= 4)
            kind = $urandom_range(0, 3);
        case (kind)
            0, 1:
            begin
                case ($urandom_range(0, 4))
                    0: a = 64'($urandom_range(0, 23));
                    1: a = 64'($urandom_range(24, 255));
                    2: a = 64'($urandom_range(256, 65535));
                    3: a = 64'($urandom);
                    default: a = {$urandom, $urandom};
                endcase
                put_head(kind, a);
            end
            2, 3:
            begin
                n = $urandom_range(0, 30);
                put_head(kind, 64'(n));
                for (int i = 0; i < n; i++)
                    byte_queue.push_back(8'($urandom));
            end
            4, 5:
            begin
                n = $urandom_range(0, 3);
                put_head(kind, 64'(n));
                for (int i = 0; i < ((kind == 5) ? 2 * n : n); i++)
                    put_item(depth + 1);
            end
            6:
            begin
                put_head(6, 64'($urandom_range(0, 300)));
                put_item(depth);
            end
            default:
            begin
                // nesting chain deep enough to sometimes overflow
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    put_head(4, 1);
                put_head(0, 0);
            end
        endcase
    endfunction

    initial
    begin
        logic [63:0] big;
        errors = 0;
        words_sent = 0;
        words_seen = 0;
        error_words = 0;
        stim_done = 1'b0;
        parser_clear();
        for (int i = 0; i < MaxDepth; i++)
            p_owed[i] = 64'd0;

        // Directed: integer extremes, empty string and containers, then error and nesting cases
        put_head(0, 0);
        put_head(1, 64'hFFFF_FFFF_FFFF_FFFF);
        put_head(2, 0);
        byte_queue.push_back(8'h7F);                // text, indefinite: info error
        put_head(4, 0);
        put_head(5, 0);
        byte_queue.push_back(8'hE0);                // major 7
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h1C);                // reserved info
        put_head(5, 64'h8000_0000_0000_0000);       // map count overflow
        big = 64'h7FFF_FFFF_FFFF_FFFF;
        put_head(5, 1);                             // map {5: [1,2]}
        put_head(0, 5);
        put_head(4, 2);
        put_head(0, 1);
        put_head(0, 2);
        put_head(6, 1);                             // tag over a string
        put_head(3, 2);
        byte_queue.push_back(8'h41);
        byte_queue.push_back(8'h42);
        for (int i = 0; i < 9; i++)                 // too deep
            put_head(4, 1);
        put_head(5, big);                           // huge map then abandon by error
        byte_queue.push_back(8'hF7);

        while (byte_queue.size() < 1900)
        begin
            if ($urandom_range(0, 19) == 0)
                byte_queue.push_back(8'($urandom)); // noise
            else
                put_item(0);
        end
        // make sure nothing is left half-parsed: force an error at the end
        byte_queue.push_back(8'hE0);
    end

    // Reset
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata);
                words_sent++;
                send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end
            if (send_gap > 0 && !(s_tvalid && !s_tready))
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (!(s_tvalid && !s_tready))
            begin
                if (byte_queue.size() > 0)
                begin
                    s_tdata  <= byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid  <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // Monitor with random back-pressure
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        item_end_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                if (m_tdata[34:32] != ST_OK)
                    error_words++;
                if (item_ends.size() == 0)
                begin
                    $error("unexpected word: item_length %0d status %0d",
                           m_tdata[31:0], m_tdata[34:32]);
                    errors++;
                end
                else
                begin
                    want = item_ends.pop_front();
                    if (m_tdata[31:0] != want.length)
                    begin
                        $error("item_length: expected %0d actual %0d",
                               want.length, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[34:32] != want.status)
                    begin
                        $error("status: expected %0d actual %0d",
                               want.status, m_tdata[34:32]);
                        errors++;
                    end
                end
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Completion and timeout
    initial
    begin
        cycles = 0;
        while (!(stim_done && item_ends.size() == 0) && cycles < 200000)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= 200000)
        begin
            $display("tb_cbor_item_delimiter_top: FAIL");
            $finish;
        end
        else
        begin
            repeat (40) @(posedge clk);
            $display("Sent %0d bytes, checked %0d result words (%0d errors flagged).",
                     words_sent, words_seen, error_words);
            if (errors == 0 && item_ends.size() == 0)
                $display("tb_cbor_item_delimiter_top: PASS");
            else
                $display("tb_cbor_item_delimiter_top: FAIL");
            $finish;
        end
    end
endmodule
